// ===== hw/rtl/rwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwa_pkg
// Shared widths, constants and state type for the engine speed averager.
// ----------------------------------------------------------------------------
package rwa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_BITS = 7;
    localparam int OUT_BITS    = 16;
    localparam int NUM_BITS    = SAMPLE_BITS + WINDOW_BITS;
    localparam int STEP_BITS   = $clog2(NUM_BITS + 1);
    localparam int ADDR_BITS   = 2;
    localparam int DATA_BITS   = 32;

    localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = ADDR_BITS'(0);

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(2);
    localparam logic [OUT_BITS-1:0] SMOOTH_DROP_MASK = OUT_BITS'(15);
    localparam logic [OUT_BITS-1:0] SAMPLE_DROP_MASK = OUT_BITS'(63);

    localparam logic [STEP_BITS-1:0] MUL_LAST = STEP_BITS'(WINDOW_BITS - 1);
    localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(NUM_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/rwa_sample_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwa_sample_if
// Valid/ready channel that carries one engine speed sample per item.
// ----------------------------------------------------------------------------
interface rwa_sample_if;

    logic                             valid;
    logic                             ready;
    logic [rwa_pkg::SAMPLE_BITS-1:0] rpm_sample;

    modport source (output valid, output rpm_sample, input ready);
    modport sink (input valid, input rpm_sample, output ready);

endinterface
`default_nettype wire

// ===== hw/rtl/rwa_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rwa_result_if
// Valid/ready channel that carries one smoothed speed result per item.
// ----------------------------------------------------------------------------
interface rwa_result_if;

    logic                          valid;
    logic                          ready;
    logic [rwa_pkg::OUT_BITS-1:0] smoothed_rpm;
    logic [rwa_pkg::OUT_BITS-1:0] smoothed_rpm_coarse;
    logic [rwa_pkg::OUT_BITS-1:0] sample_rpm_coarse;

    modport source (
        output valid, output smoothed_rpm, output smoothed_rpm_coarse,
        output sample_rpm_coarse, input ready
    );
    modport sink (
        input valid, input smoothed_rpm, input smoothed_rpm_coarse,
        input sample_rpm_coarse, output ready
    );

endinterface
`default_nettype wire

// ===== hw/rtl/rpm_warmup_averager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpm_warmup_averager
// Running average of engine speed: exact mean while the window fills, then
// a first-order filter over window_length samples.
//
// Samples enter on i_sample and results leave on o_result, both valid/ready.
// The window length is written over the APB port at address 0 and reads back
// there. Each accepted item runs a shift-add multiply of the old value by the
// divisor minus one, one multiplier bit per cycle, and then a restoring
// division of the 23-bit numerator, one quotient bit per cycle. The next
// sample can be accepted in the same cycle that the result becomes valid.
// With a window of zero, or a count above the window, the sample is taken as
// is and goes through the done state to the output register. No new sample
// is accepted until the last item has been loaded into the output register,
// so the serial arithmetic sets the rate.
// The result waits in an output register while the next item is accepted
// and computed; a finished item holds in its last step until the receiver
// takes the pending result. Reset clears the smoothed value and the count,
// sets the window to 2 and empties the output.
// ----------------------------------------------------------------------------
module rpm_warmup_averager (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    rwa_sample_if.sink                         i_sample,
    rwa_result_if.source                       o_result,
    input  wire                                i_psel,
    input  wire                                i_penable,
    input  wire                                i_pwrite,
    input  wire  [rwa_pkg::ADDR_BITS-1:0]      i_paddr,
    input  wire  [rwa_pkg::DATA_BITS-1:0]      i_pwdata,
    output logic [rwa_pkg::DATA_BITS-1:0]      o_prdata,
    output logic                               o_pready
);

    localparam int SB = rwa_pkg::SAMPLE_BITS;
    localparam int WB = rwa_pkg::WINDOW_BITS;
    localparam int NB = rwa_pkg::NUM_BITS;
    localparam int OB = rwa_pkg::OUT_BITS;
    localparam int TB = rwa_pkg::STEP_BITS;

    rwa_pkg::t_state r_state, n_state;

    logic [WB-1:0] r_window, n_window;
    logic [SB-1:0] r_smooth, n_smooth;
    logic [WB-1:0] r_count, n_count;
    logic [WB-1:0] r_div, n_div;
    logic [WB-1:0] r_mplier, n_mplier;
    logic [NB-1:0] r_mcand, n_mcand;
    logic [NB-1:0] r_acc, n_acc;
    logic [WB-1:0] r_rem, n_rem;
    logic [TB-1:0] r_step, n_step;
    logic [SB-1:0] r_sample, n_sample;
    logic          r_out_valid, n_out_valid;
    logic [OB-1:0] r_out_smooth, n_out_smooth;
    logic [OB-1:0] r_out_sample, n_out_sample;

    logic          w_accept;
    logic          w_load_out;
    logic          w_bypass;
    logic          w_cfg_write;
    logic [WB-1:0] w_divisor;
    logic [WB:0]   w_rem_sh;
    logic [WB:0]   w_rem_diff;
    logic          w_ge;

    assign w_cfg_write = i_psel && i_penable && i_pwrite && o_pready
                         && (i_paddr == rwa_pkg::ADDR_WINDOW);
    assign o_pready    = 1'b1;
    assign o_prdata    = (i_paddr == rwa_pkg::ADDR_WINDOW) ?
                         rwa_pkg::DATA_BITS'(r_window) : '0;

    assign w_accept = i_sample.valid && i_sample.ready;
    assign w_bypass = (r_window == '0) || (r_count > r_window);
    assign w_divisor = (r_count == r_window) ? r_window : r_count + WB'(1);

    assign w_rem_sh   = {r_rem, r_acc[NB-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_div};
    assign w_ge       = (w_rem_sh >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        case (r_state)
            rwa_pkg::ST_IDLE: begin
                if (i_sample.valid) begin
                    n_state = w_bypass ? rwa_pkg::ST_DONE : rwa_pkg::ST_MUL;
                end
            end
            rwa_pkg::ST_MUL: begin
                if (r_step == rwa_pkg::MUL_LAST) begin
                    n_state = rwa_pkg::ST_DIV;
                end
            end
            rwa_pkg::ST_DIV: begin
                if (r_step == rwa_pkg::DIV_LAST) begin
                    n_state = rwa_pkg::ST_DONE;
                end
            end
            rwa_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = rwa_pkg::ST_IDLE;
                end
            end
            default: n_state = rwa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_sample.ready = 1'b0;
        w_load_out     = 1'b0;
        case (r_state)
            rwa_pkg::ST_IDLE: i_sample.ready = 1'b1;
            rwa_pkg::ST_DONE: w_load_out = !r_out_valid || o_result.ready;
            default: begin
                i_sample.ready = 1'b0;
                w_load_out     = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_window     = r_window;
        n_smooth     = r_smooth;
        n_count      = r_count;
        n_div        = r_div;
        n_mplier     = r_mplier;
        n_mcand      = r_mcand;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_step       = r_step;
        n_sample     = r_sample;
        n_out_valid  = r_out_valid;
        n_out_smooth = r_out_smooth;
        n_out_sample = r_out_sample;

        if (w_cfg_write) begin
            n_window = i_pwdata[WB-1:0];
        end
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rwa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_sample = i_sample.rpm_sample;
                    n_acc    = NB'(i_sample.rpm_sample);
                    n_step   = '0;
                    if (w_bypass) begin
                        n_count = WB'(1);
                    end else begin
                        n_count  = w_divisor;
                        n_div    = w_divisor;
                        n_mplier = w_divisor - WB'(1);
                        n_mcand  = NB'(r_smooth);
                    end
                end
            end
            rwa_pkg::ST_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[NB-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[WB-1:1]};
                n_step   = r_step + TB'(1);
                if (r_step == rwa_pkg::MUL_LAST) begin
                    n_step = '0;
                    n_rem  = '0;
                end
            end
            rwa_pkg::ST_DIV: begin
                n_rem  = w_ge ? w_rem_diff[WB-1:0] : w_rem_sh[WB-1:0];
                n_acc  = {r_acc[NB-2:0], w_ge};
                n_step = r_step + TB'(1);
            end
            rwa_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_smooth     = r_acc[SB-1:0];
                    n_out_valid  = 1'b1;
                    n_out_smooth = OB'(r_acc[SB-1:0]);
                    n_out_sample = OB'(r_sample);
                end
            end
            default: n_step = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rwa_pkg::ST_IDLE;
            r_window    <= rwa_pkg::WINDOW_RESET;
            r_smooth    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_smooth    <= n_smooth;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div        <= n_div;
        r_mplier     <= n_mplier;
        r_mcand      <= n_mcand;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_sample     <= n_sample;
        r_out_smooth <= n_out_smooth;
        r_out_sample <= n_out_sample;
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.smoothed_rpm        = r_out_smooth;
    assign o_result.smoothed_rpm_coarse = r_out_smooth & ~rwa_pkg::SMOOTH_DROP_MASK;
    assign o_result.sample_rpm_coarse   = r_out_sample & ~rwa_pkg::SAMPLE_DROP_MASK;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rwa_pkg::ST_DIV) |-> (r_rem < r_div))
        else $error("Division remainder reached the divisor.");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != rwa_pkg::ST_IDLE))
        else $error("An accepted item did not start work.");

    a_state_tracks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_out_valid && (r_out_smooth == OB'(r_smooth))))
        else $error("Stored smoothed value differs from the delivered result.");

    a_mul_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rwa_pkg::ST_MUL) |-> (r_step <= rwa_pkg::MUL_LAST))
        else $error("Multiply step counter ran past its last step.");

endmodule
`default_nettype wire
